// ----- sv/sbpf_pkg.sv -----
package sbpf_pkg;

   // Input item opcodes
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RX_BYTE = 2'd2;

   // Packet bytes
   localparam logic [7:0] HDR_BYTE       = 8'hFF;
   localparam logic [7:0] INST_READ      = 8'h02;
   localparam logic [7:0] INST_WRITE     = 8'h03;
   localparam logic [7:0] READ_LEN_FIELD = 8'h04;
   localparam logic [7:0] WRITE_LEN_BASE = 8'h03;

   // Reply length beyond the data bytes
   localparam logic [4:0] REPLY_OVERHEAD = 5'd6;

   // Byte positions inside an outgoing packet
   localparam logic [3:0] IDX_HDR0     = 4'd0;
   localparam logic [3:0] IDX_HDR1     = 4'd1;
   localparam logic [3:0] IDX_ID       = 4'd2;
   localparam logic [3:0] IDX_LEN      = 4'd3;
   localparam logic [3:0] IDX_INST     = 4'd4;
   localparam logic [3:0] IDX_ADDR     = 4'd5;
   localparam logic [3:0] IDX_BODY     = 4'd6;
   localparam logic [3:0] READ_LAST_IDX = 4'd7;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      JOB_WRITE,
      JOB_READ,
      JOB_REPLY,
      JOB_REJECT
   } sbpf_job_kind_type;

   typedef struct packed {
      sbpf_job_kind_type kind;
      logic [7:0]        id;
      logic [7:0]        addr;
      logic [3:0]        cnt;
      logic [63:0]       data;
      logic              ok;
   } sbpf_job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } sbpf_qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PACKET,
      BK_STATUS
   } sbpf_back_state_type;

endpackage

// ----- sv/sbpf_front.sv -----
module sbpf_front #(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [1:0]            opcode,
   input  logic [7:0]            servo_id,
   input  logic [7:0]            reg_addr,
   input  logic [3:0]            byte_count,
   input  logic [63:0]           payload,
   input  logic [7:0]            rx_byte,
   input  sbpf_pkg::sbpf_qstat_type qstat,
   output logic                  job_push,
   output sbpf_pkg::sbpf_job_type job
);
   import sbpf_pkg::*;

   logic        read_pending_ff, read_pending_in;
   logic [7:0]  pending_id_ff, pending_id_in;
   logic [3:0]  pending_count_ff, pending_count_in;
   logic [3:0]  rx_position_ff, rx_position_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic        header_match_ff, header_match_in;
   logic [63:0] rx_data_ff, rx_data_in;

   logic        accept, is_cmd, oversize, arm, rx_take, at_last, reply_ok;
   logic [4:0]  last_pos;
   logic [3:0]  data_sel;

   assign accept   = push && !qstat.full;
   assign is_cmd   = (opcode == OP_WRITE) || (opcode == OP_READ);
   assign oversize = {1'b0, byte_count} > 5'(MAX_DATA_BYTES);
   assign arm      = accept && (opcode == OP_READ) && !oversize;
   assign rx_take  = accept && (opcode == OP_RX_BYTE) && read_pending_ff;
   assign last_pos = {1'b0, pending_count_ff} + REPLY_OVERHEAD - 5'd1;
   assign at_last  = {1'b0, rx_position_ff} == last_pos;
   assign data_sel = rx_position_ff - IDX_ADDR;
   assign reply_ok = header_match_ff && (~rx_sum_ff == rx_byte);

   always_comb begin
      read_pending_in  = read_pending_ff;
      pending_id_in    = pending_id_ff;
      pending_count_in = pending_count_ff;
      rx_position_in   = rx_position_ff;
      rx_sum_in        = rx_sum_ff;
      header_match_in  = header_match_ff;
      rx_data_in       = rx_data_ff;
      if (arm) begin
         // re-arm, abandoning any earlier reception
         read_pending_in  = 1'b1;
         pending_id_in    = servo_id;
         pending_count_in = byte_count;
         rx_position_in   = '0;
         rx_sum_in        = '0;
         header_match_in  = 1'b1;
         rx_data_in       = '0;
      end else if (rx_take) begin
         if (at_last) begin
            read_pending_in = 1'b0;
            rx_position_in  = '0;
         end else begin
            if ((rx_position_ff == IDX_HDR0 || rx_position_ff == IDX_HDR1) &&
                rx_byte != HDR_BYTE) begin
               header_match_in = 1'b0;
            end
            if (rx_position_ff == IDX_ID && rx_byte != pending_id_ff) begin
               header_match_in = 1'b0;
            end
            if (rx_position_ff >= IDX_ID) begin
               rx_sum_in = rx_sum_ff + rx_byte;
            end
            if (rx_position_ff >= IDX_ADDR && !data_sel[3]) begin
               rx_data_in = rx_data_ff | (64'(rx_byte) << {data_sel[2:0], 3'b000});
            end
            rx_position_in = rx_position_ff + 4'd1;
         end
      end
   end

   always_comb begin
      job_push = accept && (is_cmd || (rx_take && at_last));
      job.id   = servo_id;
      job.addr = reg_addr;
      job.cnt  = byte_count;
      job.ok   = reply_ok;
      if (is_cmd) begin
         job.data = payload;
         if (oversize) begin
            job.kind = JOB_REJECT;
         end else if (opcode == OP_WRITE) begin
            job.kind = JOB_WRITE;
         end else begin
            job.kind = JOB_READ;
         end
      end else begin
         job.kind = JOB_REPLY;
         job.data = reply_ok ? rx_data_ff : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pending_ff  <= 1'b0;
         pending_id_ff    <= '0;
         pending_count_ff <= '0;
         rx_position_ff   <= '0;
         rx_sum_ff        <= '0;
         header_match_ff  <= 1'b1;
         rx_data_ff       <= '0;
      end else begin
         read_pending_ff  <= read_pending_in;
         pending_id_ff    <= pending_id_in;
         pending_count_ff <= pending_count_in;
         rx_position_ff   <= rx_position_in;
         rx_sum_ff        <= rx_sum_in;
         header_match_ff  <= header_match_in;
         rx_data_ff       <= rx_data_in;
      end
   end

endmodule

// ----- sv/sbpf_queue.sv -----
module sbpf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sbpf_pkg::sbpf_job_type   push_job,
   input  logic                     pop,
   output sbpf_pkg::sbpf_job_type   head_job,
   output sbpf_pkg::sbpf_qstat_type qstat
);
   import sbpf_pkg::*;

   sbpf_job_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign qstat.empty = count_ff == '0;
   assign qstat.full  = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/sbpf_back.sv -----
module sbpf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sbpf_pkg::sbpf_job_type   head_job,
   input  sbpf_pkg::sbpf_qstat_type qstat,
   output logic                     job_pop,
   input  logic                     pop,
   output logic                     empty,
   output logic [7:0]               tx_byte,
   output logic                     tx_valid,
   output logic                     last,
   output logic                     reply_done,
   output logic                     reply_ok,
   output logic [63:0]              reply_data,
   output logic                     request_error
);
   import sbpf_pkg::*;

   sbpf_back_state_type state_ff, state_in;
   sbpf_job_type        job_ff;
   logic [3:0]          idx_ff, idx_in;
   logic [7:0]          sum_ff, sum_in;
   logic [63:0]         shift_ff, shift_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff;
   logic        out_txv_ff, out_last_ff, out_done_ff, out_ok_ff, out_err_ff;
   logic [63:0] out_data_ff;

   logic        out_ready, emit, is_write, at_end;
   logic [3:0]  last_idx;
   logic [7:0]  pkt_byte;

   assign out_ready = !out_valid_ff || pop;
   assign is_write  = job_ff.kind == JOB_WRITE;
   assign last_idx  = is_write ? job_ff.cnt + IDX_BODY : READ_LAST_IDX;
   assign at_end    = idx_ff == last_idx;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               if (head_job.kind == JOB_WRITE || head_job.kind == JOB_READ) begin
                  state_in = BK_PACKET;
               end else begin
                  state_in = BK_STATUS;
               end
            end
         end
         BK_PACKET: begin
            if (out_ready && at_end) begin
               state_in = BK_IDLE;
            end
         end
         BK_STATUS: begin
            if (out_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Packet byte at the current position
   always_comb begin
      case (idx_ff)
         IDX_HDR0: pkt_byte = HDR_BYTE;
         IDX_HDR1: pkt_byte = HDR_BYTE;
         IDX_ID:   pkt_byte = job_ff.id;
         IDX_LEN:  pkt_byte = is_write ? WRITE_LEN_BASE + 8'(job_ff.cnt) : READ_LEN_FIELD;
         IDX_INST: pkt_byte = is_write ? INST_WRITE : INST_READ;
         IDX_ADDR: pkt_byte = job_ff.addr;
         default: begin
            if (at_end) begin
               pkt_byte = ~sum_ff;
            end else if (is_write) begin
               pkt_byte = shift_ff[7:0];
            end else begin
               pkt_byte = 8'(job_ff.cnt);
            end
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      job_pop  = (state_ff == BK_IDLE) && !qstat.empty;
      emit     = (state_ff != BK_IDLE) && out_ready;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      shift_in = shift_ff;
      if (job_pop) begin
         idx_in   = '0;
         sum_in   = '0;
         shift_in = head_job.data;
      end else if (state_ff == BK_PACKET && out_ready) begin
         idx_in = idx_ff + 4'd1;
         if (idx_ff >= IDX_ID && !at_end) begin
            sum_in = sum_ff + pkt_byte;
         end
         if (is_write && idx_ff >= IDX_BODY && !at_end) begin
            shift_in = shift_ff >> 8;
         end
      end
      out_valid_in = emit ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= head_job;
      end
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      shift_ff <= shift_in;
      if (emit) begin
         if (state_ff == BK_PACKET) begin
            out_byte_ff <= pkt_byte;
            out_txv_ff  <= 1'b1;
            out_last_ff <= at_end;
            out_done_ff <= 1'b0;
            out_ok_ff   <= 1'b0;
            out_data_ff <= '0;
            out_err_ff  <= 1'b0;
         end else begin
            out_byte_ff <= '0;
            out_txv_ff  <= 1'b0;
            out_last_ff <= 1'b1;
            out_done_ff <= job_ff.kind == JOB_REPLY;
            out_ok_ff   <= (job_ff.kind == JOB_REPLY) && job_ff.ok;
            out_data_ff <= (job_ff.kind == JOB_REPLY) ? job_ff.data : 64'd0;
            out_err_ff  <= job_ff.kind == JOB_REJECT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty         = !out_valid_ff;
   assign tx_byte       = out_byte_ff;
   assign tx_valid      = out_txv_ff;
   assign last          = out_last_ff;
   assign reply_done    = out_done_ff;
   assign reply_ok      = out_ok_ff;
   assign reply_data    = out_data_ff;
   assign request_error = out_err_ff;

endmodule

// ----- sv/servo_bus_packet_framer_core.sv -----
// Master-side framer for a half-duplex serial servo bus. Push one item per
// cycle while req_full is low: a write command (opcode 0) yields the packet
// FF FF id len+3 03 addr data... checksum, one byte per result; a read command
// (opcode 1) yields FF FF id 04 02 addr len checksum and arms reception of a
// len+6 byte reply; opcode 2 feeds one received byte. Received bytes are
// absorbed silently until the last one, which yields a single result with
// reply_done, reply_ok (headers, id and checksum) and the data bytes. A command
// whose byte count exceeds MAX_DATA_BYTES yields one result with request_error
// and sends nothing. Every run of results ends with rsp_last. The front takes
// one item per cycle into a four-entry job queue while it has room; the back
// sequencer pulls a job and then emits one packet byte per cycle unless the
// output register stalls, and pulls the next job only when it is back in idle.
module servo_bus_packet_framer_core #(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_servo_id,
   input  logic [7:0]  req_reg_addr,
   input  logic [3:0]  req_byte_count,
   input  logic [63:0] req_payload,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_valid,
   output logic        rsp_last,
   output logic        rsp_reply_done,
   output logic        rsp_reply_ok,
   output logic [63:0] rsp_reply_data,
   output logic        rsp_request_error
);
   import sbpf_pkg::*;

   sbpf_qstat_type qstat;
   sbpf_job_type   push_job;
   sbpf_job_type   head_job;
   logic           job_push;
   logic           job_pop;

   // Stall the input side only when the job queue has no room
   assign req_full = qstat.full;

   // Classify items and track the pending reply
   sbpf_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .opcode     (req_opcode),
      .servo_id   (req_servo_id),
      .reg_addr   (req_reg_addr),
      .byte_count (req_byte_count),
      .payload    (req_payload),
      .rx_byte    (req_rx_byte),
      .qstat      (qstat),
      .job_push   (job_push),
      .job        (push_job)
   );

   // Decouple classification from byte emission
   sbpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // Serialize packets and status results into the output register
   sbpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .qstat         (qstat),
      .job_pop       (job_pop),
      .pop           (rsp_pop),
      .empty         (rsp_empty),
      .tx_byte       (rsp_tx_byte),
      .tx_valid      (rsp_tx_valid),
      .last          (rsp_last),
      .reply_done    (rsp_reply_done),
      .reply_ok      (rsp_reply_ok),
      .reply_data    (rsp_reply_data),
      .request_error (rsp_request_error)
   );

endmodule

// ----- sv/sbpf_checker.sv -----
module sbpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_tx_valid,
   input logic        rsp_last,
   input logic        rsp_reply_done,
   input logic        rsp_reply_ok,
   input logic [63:0] rsp_reply_data,
   input logic        rsp_request_error
);

   // Hold a waiting item until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("result changed while stalled");

   // A packet byte carries no status
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_tx_valid |-> !rsp_reply_done && !rsp_request_error)
      else $error("packet byte mixed with status");

   // A status result closes its run and carries no byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_reply_done || rsp_request_error) |->
         rsp_last && !rsp_tx_valid && rsp_tx_byte == 8'd0)
      else $error("status result malformed");

   // Reply data only with a good reply
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_reply_data != 64'd0 |-> rsp_reply_ok && rsp_reply_done)
      else $error("reply data without good reply");

endmodule

bind servo_bus_packet_framer_core sbpf_checker u_sbpf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_tx_byte       (rsp_tx_byte),
   .rsp_tx_valid      (rsp_tx_valid),
   .rsp_last          (rsp_last),
   .rsp_reply_done    (rsp_reply_done),
   .rsp_reply_ok      (rsp_reply_ok),
   .rsp_reply_data    (rsp_reply_data),
   .rsp_request_error (rsp_request_error)
);
